/* rtl/tvt_pkg.sv */
// tvt_pkg: shared constants and types for the tree vote tally block
// no dependencies
`default_nettype none
package tvt_pkg;
  localparam int MAX_TREES    = 256;
  localparam int MAX_DISTINCT = 4096;
  localparam int MAX_OUT      = 64;
  localparam int DOC_W        = 31;
  localparam int TREE_W       = 8;
  localparam int VOTE_W       = 9;
  localparam int CNT_W        = $clog2(MAX_DISTINCT) + 1;
  localparam int ADDR_W       = $clog2(MAX_DISTINCT);
  localparam int HIST_D       = 257;
  localparam int HIST_AW      = 9;
  localparam int LIM_W        = 7;
  localparam int CFG_W        = 9;
  localparam int IDX_W        = 1;

  localparam logic [IDX_W-1:0] REG_RESULT_LIMIT = 1'b0;
  localparam logic [IDX_W-1:0] REG_TREE_COUNT   = 1'b1;

  localparam logic [LIM_W-1:0]  LIMIT_RESET = 7'd10;
  localparam logic [VOTE_W-1:0] TREES_RESET = 9'd256;

  typedef struct packed {
    logic                  has_pair;
    logic [DOC_W-1:0]      doc_id;
    logic [TREE_W-1:0]     tree_id;
    logic                  end_of_query;
  } in_item_t;

  typedef struct packed {
    logic [DOC_W-1:0]  chosen_doc;
    logic [VOTE_W-1:0] vote_total;
    logic              overflow;
    logic              last_result;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic tally;        // process one input beat
    logic commit_cur;   // commit pending current doc
    logic clr_start;    // begin clearing pass
    logic clr_step;     // clear one entry
    logic thr_start;    // begin threshold scan
    logic thr_step;     // scan one histogram bin
    logic emit_start;   // begin output walk
    logic emit_rd;      // issue store read
    logic emit_chk;     // evaluate read data
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cur_valid;
    logic clr_done;
    logic thr_done;
    logic emit_more;    // more store entries to read and room left
    logic take;         // current read entry selected
  } dp_stat_t;
endpackage
`default_nettype wire

/* rtl/tvt_if.sv */
// tvt_if: valid/ready channel interface carrying one payload type
// depends on tvt_pkg
`default_nettype none
interface tvt_in_if import tvt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tvt_out_if import tvt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/tvt_ram.sv */
// tvt_ram: generic single-port write, single-port registered read memory
// no dependencies
`default_nettype none
module tvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/tvt_datapath.sv */
// tvt_datapath: tally registers, per-tree marks, store, histogram, selection
// depends on tvt_pkg and tvt_ram
`default_nettype none
module tvt_datapath import tvt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire in_item_t          item,
  input  wire dp_cmd_t           cmd,
  input  wire logic [LIM_W-1:0]  result_limit,
  input  wire logic [VOTE_W-1:0] tree_count,
  output      dp_stat_t          stat,
  output      out_item_t         res
);
  // per-tree marks: valid flags in flops, last doc in a ram
  logic [MAX_TREES-1:0] tree_valid;
  logic [DOC_W-1:0]     tl_rdata;
  logic                 tl_we;
  logic [TREE_W-1:0]    tl_waddr;

  // stage register for the tally pipeline (tree mark read latency)
  logic              s1_vld;
  in_item_t          s1;
  logic              s1_tv;
  logic              s1_fwd;   // previous beat wrote the mark of this tree
  logic [DOC_W-1:0]  s1_fdoc;
  logic              tv_eff;
  logic [DOC_W-1:0]  tl_eff;

  logic              cur_valid;
  logic [DOC_W-1:0]  cur_doc;
  logic [VOTE_W-1:0] cur_vote;
  logic [CNT_W-1:0]  dcount;
  logic              ovf;

  logic [VOTE_W-1:0] cap;
  logic [LIM_W-1:0]  limit;

  // store
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [ADDR_W-1:0] st_raddr;
  logic [DOC_W-1:0]  st_doc;
  logic [VOTE_W-1:0] st_vote;

  // histogram
  logic              h_we;
  logic [HIST_AW-1:0] h_waddr;
  logic [CNT_W-1:0]  h_wdata;
  logic [HIST_AW-1:0] h_raddr;
  logic [CNT_W-1:0]  h_rdata;
  logic [HIST_AW-1:0] clr_idx;

  // commit pipeline: read histogram bin, then write incremented
  logic              cm_vld;
  logic [VOTE_W-1:0] cm_vote;
  logic              cm_fwd;   // bin read was stale, use the value just written
  logic [CNT_W-1:0]  cm_wval;
  logic [VOTE_W-1:0] commit_vote;
  logic              do_commit;
  logic              new_doc;
  logic              tree_hit;

  // threshold scan
  logic [HIST_AW-1:0] thr_idx;
  logic               thr_rd;
  logic               thr_go;
  logic [CNT_W-1:0]   acc;
  logic [VOTE_W-1:0]  thr;
  logic [CNT_W-1:0]   above;
  logic               thr_found;
  logic               thr_fin;
  logic [CNT_W-1:0]   acc_sum;

  // output walk
  logic [CNT_W-1:0]  rd_idx;
  logic [LIM_W-1:0]  kept;
  logic [CNT_W-1:0]  at_need;
  logic              take_c;

  assign cap   = (tree_count == '0) ? VOTE_W'(1) :
                 ((tree_count > VOTE_W'(MAX_TREES)) ? VOTE_W'(MAX_TREES) : tree_count);
  assign limit = (result_limit > LIM_W'(MAX_OUT)) ? LIM_W'(MAX_OUT) : result_limit;

  tvt_ram #(.WIDTH(DOC_W), .DEPTH(MAX_TREES)) u_tree_last (
    .clk, .we(tl_we), .waddr(tl_waddr), .wdata(s1.doc_id),
    .raddr(item.tree_id), .rdata(tl_rdata)
  );

  // stage 2 decisions, with the mark written by the previous beat forwarded
  assign tv_eff   = s1_tv || s1_fwd;
  assign tl_eff   = s1_fwd ? s1_fdoc : tl_rdata;
  assign new_doc  = s1_vld && s1.has_pair && (!cur_valid || s1.doc_id != cur_doc);
  assign tree_hit = s1_vld && s1.has_pair && (!tv_eff || tl_eff != s1.doc_id);
  assign tl_we    = tree_hit;
  assign tl_waddr = s1.tree_id;

  assign commit_vote = (cur_vote > cap) ? cap : cur_vote;
  assign do_commit   = (new_doc && cur_valid) || (cmd.commit_cur && cur_valid);

  assign st_we    = do_commit && (dcount < CNT_W'(MAX_DISTINCT));
  assign st_waddr = dcount[ADDR_W-1:0];

  tvt_ram #(.WIDTH(DOC_W), .DEPTH(MAX_DISTINCT)) u_st_doc (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(cur_doc),
    .raddr(st_raddr), .rdata(st_doc)
  );
  tvt_ram #(.WIDTH(VOTE_W), .DEPTH(MAX_DISTINCT)) u_st_vote (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(commit_vote),
    .raddr(st_raddr), .rdata(st_vote)
  );
  assign st_raddr = rd_idx[ADDR_W-1:0];

  assign thr_go = cmd.thr_step && !thr_fin;

  // histogram port muxing: clear, increment, or scan read
  always_comb begin
    h_we    = 1'b0;
    h_waddr = cm_vote;
    h_wdata = (cm_fwd ? cm_wval : h_rdata) + CNT_W'(1);
    h_raddr = commit_vote;
    if (cmd.clr_step) begin
      h_we    = 1'b1;
      h_waddr = clr_idx;
      h_wdata = '0;
    end else if (cm_vld) begin
      h_we = 1'b1;
    end
    if (thr_go) h_raddr = thr_idx;
  end

  tvt_ram #(.WIDTH(CNT_W), .DEPTH(HIST_D)) u_hist (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  assign acc_sum = acc + h_rdata;
  assign take_c  = (st_vote > thr) || (st_vote == thr && at_need != '0);

  // tally, clearing and selection registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_valid <= '0;
      s1_vld     <= 1'b0;
      cur_valid  <= 1'b0;
      cur_vote   <= '0;
      dcount     <= '0;
      ovf        <= 1'b0;
      cm_vld     <= 1'b0;
      cm_fwd     <= 1'b0;
      clr_idx    <= '0;
      thr_rd     <= 1'b0;
      thr_found  <= 1'b0;
      thr_fin    <= 1'b0;
      rd_idx     <= '0;
      kept       <= '0;
    end else begin
      s1_vld <= cmd.tally;
      if (cmd.tally) begin
        s1      <= item;
        s1_tv   <= tree_valid[item.tree_id];
        s1_fwd  <= tree_hit && (s1.tree_id == item.tree_id);
        s1_fdoc <= s1.doc_id;
      end
      if (tree_hit) tree_valid[s1.tree_id] <= 1'b1;
      cm_vld  <= st_we;
      cm_vote <= commit_vote;
      cm_fwd  <= st_we && cm_vld && (cm_vote == commit_vote);
      if (cm_vld) cm_wval <= h_wdata;
      if (do_commit) begin
        if (st_we) dcount <= dcount + CNT_W'(1);
        else ovf <= 1'b1;
      end
      if (new_doc) begin
        cur_valid <= 1'b1;
        cur_doc   <= s1.doc_id;
        cur_vote  <= tree_hit ? VOTE_W'(1) : '0;
      end else if (tree_hit && cur_vote != '1) begin
        cur_vote <= cur_vote + VOTE_W'(1);
      end
      if (cmd.commit_cur) cur_valid <= 1'b0;
      // threshold scan from cap down to zero
      thr_rd <= thr_go;
      if (cmd.thr_start) begin
        thr_idx   <= cap;
        acc       <= '0;
        thr       <= '0;
        above     <= '0;
        thr_found <= 1'b0;
        thr_fin   <= 1'b0;
      end else begin
        if (thr_go) thr_idx <= thr_idx - HIST_AW'(1);
        // above tracks the sum of the bins over the current one
        if (thr_rd && !thr_found) begin
          acc   <= acc_sum;
          above <= acc;
          if (acc_sum >= CNT_W'(limit)) begin
            thr_found <= 1'b1;
            thr       <= VOTE_W'(thr_idx + HIST_AW'(1));
          end
        end
        if (thr_go && thr_idx == '0) thr_fin <= 1'b1;
      end
      // output walk
      if (cmd.emit_start) begin
        rd_idx  <= '0;
        kept    <= '0;
        at_need <= (CNT_W'(limit) > above) ? CNT_W'(limit) - above : '0;
      end else begin
        if (cmd.emit_rd) rd_idx <= rd_idx + CNT_W'(1);
        if (cmd.emit_chk && take_c) begin
          kept <= kept + LIM_W'(1);
          if (!(st_vote > thr)) at_need <= at_need - CNT_W'(1);
        end
      end
      // clearing pass: histogram via sweep, flags and counters at once
      if (cmd.clr_start) begin
        clr_idx    <= '0;
        tree_valid <= '0;
        dcount     <= '0;
        ovf        <= 1'b0;
        cur_valid  <= 1'b0;
        cur_vote   <= '0;
      end else if (cmd.clr_step) begin
        clr_idx <= clr_idx + HIST_AW'(1);
      end
    end
  end

  assign stat.cur_valid = cur_valid;
  assign stat.clr_done  = (clr_idx == HIST_AW'(HIST_D - 1));
  assign stat.thr_done  = thr_fin && !thr_rd;
  assign stat.emit_more = (rd_idx < dcount) && (kept < limit);
  assign stat.take      = take_c && (kept < limit);

  assign res.chosen_doc  = st_doc;
  assign res.vote_total  = st_vote;
  assign res.overflow    = ovf;
  assign res.last_result = 1'b0;
endmodule
`default_nettype wire

/* rtl/tvt_ctrl.sv */
// tvt_ctrl: sequencer for tally, threshold scan, output walk and clearing
// depends on tvt_pkg
`default_nettype none
module tvt_ctrl import tvt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_eoq,
  output      logic      in_ready,
  input  wire dp_stat_t  stat,
  input  wire out_item_t res,
  output      dp_cmd_t   cmd,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);
  typedef enum logic [3:0] {
    S_CLR, S_TALLY, S_DRAIN, S_COMMIT, S_SETTLE, S_THR, S_WAIT,
    S_EMIT_START, S_RD, S_CHK
  } state_t;

  state_t state;
  logic [1:0] drain;
  logic       hold_vld;   // a taken entry waits to be sent
  out_item_t  hold;

  logic      accept;
  logic      walk_end;    // walk finished and the last beat can be loaded
  logic      load_out;
  logic      load_last;
  out_item_t load_data;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_TALLY);
  assign walk_end  = (state == S_RD) && !stat.emit_more && (!out_valid || out_ready);
  assign load_last = walk_end && hold_vld;
  assign load_out  = load_last || ((state == S_CHK) && stat.take && hold_vld);

  // held entry goes out, marked last at the end of the walk
  always_comb begin
    load_data             = hold;
    load_data.last_result = load_last;
  end

  // commands from state
  always_comb begin
    cmd            = '0;
    cmd.tally      = accept;
    cmd.commit_cur = (state == S_COMMIT);
    cmd.clr_step   = (state == S_CLR);
    cmd.thr_step   = (state == S_THR);
    cmd.emit_start = (state == S_EMIT_START);
    cmd.emit_rd    = (state == S_RD) && stat.emit_more && (!out_valid || out_ready);
    cmd.emit_chk   = (state == S_CHK);
    cmd.thr_start  = (state == S_SETTLE);
    cmd.clr_start  = walk_end;
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      drain     <= '0;
      out_valid <= 1'b0;
      hold_vld  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        out_data  <= load_data;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR:   if (stat.clr_done) state <= S_TALLY;
        S_TALLY: if (accept && in_eoq) begin
          state <= S_DRAIN;
          drain <= 2'd2;
        end
        S_DRAIN: begin
          drain <= drain - 2'd1;
          if (drain == 2'd1) state <= S_COMMIT;
        end
        S_COMMIT: state <= S_SETTLE;
        S_SETTLE: if (drain == 2'd0) state <= S_THR;
        S_THR:    if (stat.thr_done) state <= S_WAIT;
        S_WAIT:   if (stat.thr_done) state <= S_EMIT_START;
        S_EMIT_START: state <= S_RD;
        S_RD: begin
          if (cmd.emit_rd) begin
            state <= S_CHK;
          end else if (walk_end) begin
            hold_vld <= 1'b0;
            state    <= S_CLR;
          end
        end
        S_CHK: begin
          if (stat.take) begin
            hold     <= res;
            hold_vld <= 1'b1;
          end
          state <= S_RD;
        end
        default: state <= S_CLR;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/tree_vote_tally_top_n_core.sv */
// tree_vote_tally_top_n_core: top level, one query at a time
// pipeline: tally pipeline 2 deep; after the end-of-query beat the controller drains
// and commits, then runs a threshold scan from cap down to zero, then an output walk
// over the stored documents until result_limit are taken, stalled by the receiver
// throughput: one pair per cycle during tally; no input beats while selecting
// reset: synchronous; a clearing pass over the 257 histogram bins runs
// after reset and after each query, the input is not ready meanwhile
`default_nettype none
module tree_vote_tally_top_n_core import tvt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  tvt_in_if.sink                 in_ch,
  tvt_out_if.source              out_ch,
  input wire logic               cfg_we,
  input wire logic [IDX_W-1:0]   cfg_index,
  input wire logic [CFG_W-1:0]   cfg_data
);
  logic [LIM_W-1:0]  result_limit;
  logic [VOTE_W-1:0] tree_count;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  out_item_t         res;
  logic              out_valid;
  out_item_t         out_data;
  logic              in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_limit <= LIMIT_RESET;
      tree_count   <= TREES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESULT_LIMIT: result_limit <= cfg_data[LIM_W-1:0];
        REG_TREE_COUNT:   tree_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  tvt_datapath u_dp (
    .clk, .rst, .item(in_ch.data), .cmd, .result_limit, .tree_count,
    .stat, .res
  );

  tvt_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_eoq(in_ch.data.end_of_query),
    .in_ready, .stat, .res, .cmd, .out_valid, .out_ready(out_ch.ready),
    .out_data
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // a pending result is not withdrawn
  a_out_keep: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid) else $error("result dropped");
  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> $stable(out_data)) else $error("result changed");
endmodule
`default_nettype wire
